[sv/tmsp_pkg.sv]
// ----------------------------------------------------------------------------
// tmsp_pkg
// Shared types and constants for the tracker module stream parser: result
// kinds, header offsets, signature words and the result record.
// ----------------------------------------------------------------------------
package tmsp_pkg;

    // result kinds
    localparam logic [2:0] KIND_SAMPLE      = 3'd0;
    localparam logic [2:0] KIND_SONG        = 3'd1;
    localparam logic [2:0] KIND_NOTE        = 3'd2;
    localparam logic [2:0] KIND_DONE        = 3'd3;
    localparam logic [2:0] KIND_SHORT_FILE  = 3'd4;
    localparam logic [2:0] KIND_BAD_SIG     = 3'd5;
    localparam logic [2:0] KIND_NO_PATTERNS = 3'd6;

    // header layout offsets
    localparam logic [10:0] OFF_SAMPLES_START = 11'd20;
    localparam logic [10:0] OFF_SONG_LEN      = 11'd950;
    localparam logic [10:0] OFF_RESTART       = 11'd951;
    localparam logic [10:0] OFF_TABLE_START   = 11'd952;
    localparam logic [10:0] OFF_TABLE_END     = 11'd1080;
    localparam logic [10:0] OFF_SIG_LAST      = 11'd1083;

    // accepted signature words, first byte in the top
    localparam logic [31:0] SIG_MK   = 32'h4D2E4B2E;
    localparam logic [31:0] SIG_MK2  = 32'h4D214B21;
    localparam logic [31:0] SIG_4CHN = 32'h3443484E;
    localparam logic [31:0] SIG_FLT4 = 32'h464C5434;

    // result queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_HEADER   = 2'd0,
        PH_PATTERN  = 2'd1,
        PH_FINISHED = 2'd2
    } phase_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [16:0] first_word;
        logic [16:0] second_word;
        logic [16:0] third_word;
        logic [7:0]  first_byte;
        logic [7:0]  second_byte;
        logic [3:0]  low_nibble;
    } result_t;

    // up to two results produced by one byte, in output order
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } result_pair_t;

endpackage

[sv/tmsp_decode.sv]
// ----------------------------------------------------------------------------
// tmsp_decode
// Per-byte parser state and field decode. Each accepted byte updates the
// header/pattern state and yields zero, one or two results.
// ----------------------------------------------------------------------------
module tmsp_decode
    import tmsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   data_byte,
    input  logic         end_of_file,
    output result_pair_t results
);

    // field positions inside one 30-byte sample header
    localparam logic [4:0] SLOT_LEN_HI   = 5'd22;
    localparam logic [4:0] SLOT_LEN_LO   = 5'd23;
    localparam logic [4:0] SLOT_FINE     = 5'd24;
    localparam logic [4:0] SLOT_VOL      = 5'd25;
    localparam logic [4:0] SLOT_LSTART_H = 5'd26;
    localparam logic [4:0] SLOT_LSTART_L = 5'd27;
    localparam logic [4:0] SLOT_LLEN_H   = 5'd28;
    localparam logic [4:0] SLOT_LAST     = 5'd29;

    phase_t      phase_reg, phase_next;
    logic [10:0] hdr_off_reg, hdr_off_next;
    logic [4:0]  slot_reg, slot_next;
    logic [18:0] pat_cnt_reg, pat_cnt_next;
    logic [7:0]  pat_total_reg, pat_total_next;
    logic [7:0]  high_reg, high_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] lstart_reg, lstart_next;
    logic [15:0] llen_reg, llen_next;
    logic [3:0]  fine_reg, fine_next;
    logic [7:0]  vol_reg, vol_next;
    logic [7:0]  song_len_reg, song_len_next;
    logic [7:0]  restart_reg, restart_next;
    logic [23:0] sig_reg, sig_next;
    logic [23:0] note_reg, note_next;

    logic        main_valid, tail_valid;
    result_t     main_res, tail_res;
    logic [31:0] sig_word;
    logic        sig_ok;
    logic [18:0] pat_limit;

    assign sig_word  = {sig_reg, data_byte};
    assign sig_ok    = (sig_word == SIG_MK) || (sig_word == SIG_MK2) ||
                       (sig_word == SIG_4CHN) || (sig_word == SIG_FLT4);
    assign pat_limit = {1'b0, pat_total_reg, 10'b0};

    // next state and results
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_off_next   = hdr_off_reg;
        slot_next      = slot_reg;
        pat_cnt_next   = pat_cnt_reg;
        pat_total_next = pat_total_reg;
        high_next      = high_reg;
        len_next       = len_reg;
        lstart_next    = lstart_reg;
        llen_next      = llen_reg;
        fine_next      = fine_reg;
        vol_next       = vol_reg;
        song_len_next  = song_len_reg;
        restart_next   = restart_reg;
        sig_next       = sig_reg;
        note_next      = note_reg;
        main_valid     = 1'b0;
        tail_valid     = 1'b0;
        main_res       = '0;
        tail_res       = '0;
        tail_res.kind  = KIND_SHORT_FILE;

        if (accept)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    sig_next = {sig_reg[15:0], data_byte};
                    // sample headers
                    if (hdr_off_reg >= OFF_SAMPLES_START && hdr_off_reg < OFF_SONG_LEN)
                    begin
                        slot_next = (slot_reg == SLOT_LAST) ? 5'd0 : slot_reg + 5'd1;
                        unique case (slot_reg)
                            SLOT_LEN_HI:   len_next    = {data_byte, 8'h00};
                            SLOT_LEN_LO:   len_next    = {len_reg[15:8], data_byte};
                            SLOT_FINE:     fine_next   = data_byte[3:0];
                            SLOT_VOL:      vol_next    = data_byte;
                            SLOT_LSTART_H: lstart_next = {data_byte, 8'h00};
                            SLOT_LSTART_L: lstart_next = {lstart_reg[15:8], data_byte};
                            SLOT_LLEN_H:   llen_next   = {data_byte, 8'h00};
                            SLOT_LAST:
                            begin
                                llen_next              = {llen_reg[15:8], data_byte};
                                main_valid             = 1'b1;
                                main_res.kind          = KIND_SAMPLE;
                                main_res.first_word    = {len_reg, 1'b0};
                                main_res.second_word   = {lstart_reg, 1'b0};
                                main_res.third_word    = {llen_reg[15:8], data_byte, 1'b0};
                                main_res.first_byte    = vol_reg;
                                main_res.low_nibble    = fine_reg;
                            end
                            default: ;
                        endcase
                    end
                    else if (hdr_off_reg == OFF_SONG_LEN)
                    begin
                        song_len_next = data_byte;
                    end
                    else if (hdr_off_reg == OFF_RESTART)
                    begin
                        restart_next = data_byte;
                    end
                    else if (hdr_off_reg >= OFF_TABLE_START && hdr_off_reg < OFF_TABLE_END)
                    begin
                        if (data_byte > high_reg)
                        begin
                            high_next = data_byte;
                        end
                    end

                    // signature check at the last header byte
                    if (hdr_off_reg >= OFF_SIG_LAST)
                    begin
                        main_valid = 1'b1;
                        if (!sig_ok)
                        begin
                            main_res.kind = KIND_BAD_SIG;
                            phase_next    = PH_FINISHED;
                        end
                        else
                        begin
                            pat_total_next = high_reg + 8'd1;
                            if (pat_total_next == 8'd0)
                            begin
                                main_res.kind = KIND_NO_PATTERNS;
                                phase_next    = PH_FINISHED;
                            end
                            else
                            begin
                                main_res.kind        = KIND_SONG;
                                main_res.first_word  = {9'd0, pat_total_next};
                                main_res.first_byte  = song_len_reg;
                                main_res.second_byte = restart_reg;
                                phase_next           = PH_PATTERN;
                                pat_cnt_next         = '0;
                            end
                        end
                    end
                    else
                    begin
                        hdr_off_next = hdr_off_reg + 11'd1;
                    end

                    if (end_of_file && phase_next != PH_FINISHED)
                    begin
                        tail_valid = 1'b1;
                    end
                end

                PH_PATTERN:
                begin
                    // one note per four bytes
                    if (pat_cnt_reg[1:0] != 2'd3)
                    begin
                        note_next = {note_reg[15:0], data_byte};
                    end
                    else
                    begin
                        main_valid           = 1'b1;
                        main_res.kind        = KIND_NOTE;
                        main_res.first_word  = {5'd0, note_reg[19:16], note_reg[15:8]};
                        main_res.first_byte  = {note_reg[23:20], note_reg[7:4]};
                        main_res.second_byte = data_byte;
                        main_res.low_nibble  = note_reg[3:0];
                    end
                    pat_cnt_next = pat_cnt_reg + 19'd1;
                    if (pat_cnt_next >= pat_limit)
                    begin
                        tail_valid    = 1'b1;
                        tail_res.kind = KIND_DONE;
                        phase_next    = PH_FINISHED;
                    end
                    else if (end_of_file)
                    begin
                        tail_valid = 1'b1;
                    end
                end

                default: ;
            endcase

            // end of file restarts the parser for the next file
            if (end_of_file)
            begin
                phase_next     = PH_HEADER;
                hdr_off_next   = '0;
                slot_next      = '0;
                pat_cnt_next   = '0;
                pat_total_next = '0;
                high_next      = '0;
                len_next       = '0;
                lstart_next    = '0;
                llen_next      = '0;
                fine_next      = '0;
                vol_next       = '0;
                song_len_next  = '0;
                restart_next   = '0;
                sig_next       = '0;
                note_next      = '0;
            end
        end
    end

    // pack results in output order
    always_comb
    begin
        results.valid0 = main_valid || tail_valid;
        results.valid1 = main_valid && tail_valid;
        results.res0   = main_valid ? main_res : tail_res;
        results.res1   = tail_res;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_off_reg   <= '0;
            slot_reg      <= '0;
            pat_cnt_reg   <= '0;
            pat_total_reg <= '0;
            high_reg      <= '0;
            len_reg       <= '0;
            lstart_reg    <= '0;
            llen_reg      <= '0;
            fine_reg      <= '0;
            vol_reg       <= '0;
            song_len_reg  <= '0;
            restart_reg   <= '0;
            sig_reg       <= '0;
            note_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_off_reg   <= hdr_off_next;
            slot_reg      <= slot_next;
            pat_cnt_reg   <= pat_cnt_next;
            pat_total_reg <= pat_total_next;
            high_reg      <= high_next;
            len_reg       <= len_next;
            lstart_reg    <= lstart_next;
            llen_reg      <= llen_next;
            fine_reg      <= fine_next;
            vol_reg       <= vol_next;
            song_len_reg  <= song_len_next;
            restart_reg   <= restart_next;
            sig_reg       <= sig_next;
            note_reg      <= note_next;
        end
    end

endmodule

[sv/tmsp_queue.sv]
// ----------------------------------------------------------------------------
// tmsp_queue
// Result queue: takes up to two results per cycle, presents one at a time on
// the output channel.
// ----------------------------------------------------------------------------
module tmsp_queue
    import tmsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  result_pair_t push,
    input  logic         pop,
    output result_t      head,
    output logic         not_empty,
    output logic         has_room
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            entries [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign head         = entries[rd_ptr_reg];
    assign not_empty    = (count_reg != '0);
    // room for the two results a byte may produce
    assign has_room     = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.valid0) + PTR_W'(push.valid1);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.valid0) + CNT_W'(push.valid1)
                      - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.valid0)
        begin
            entries[wr_ptr_reg] <= push.res0;
        end
        if (push.valid1)
        begin
            entries[wr_ptr_plus1] <= push.res1;
        end
    end

endmodule

[sv/tracker_module_stream_parser_top.sv]
// ----------------------------------------------------------------------------
// tracker_module_stream_parser_top
// Streaming parser for 4-channel tracker module files.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one file byte per request, with
//   end_of_file set on the last byte of a file. The next byte starts a new file.
//   Output channel (out_valid/out_ready): one result per request: sample
//   headers, song header or signature/pattern errors, decoded notes, done, or
//   short-file error.
//   Timing: each result is registered in the result queue before it is offered.
//   Throughput: one byte per cycle while in_ready is high; the rate is set by
//   the four-entry result queue, which drains one result per cycle while
//   out_ready is high. End of file or the last pattern byte may give two results.
//   in_ready is high while the queue has room for two results, so bytes keep
//   flowing while earlier results wait to be taken.
//   Reset: the parser returns to the start of a file and the queue empties.
//   Receiver stall: results collect in the queue; once fewer than two entries
//   are free, in_ready drops until the receiver takes results again.
// ----------------------------------------------------------------------------
module tracker_module_stream_parser_top
    import tmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [16:0] first_word,
    output logic [16:0] second_word,
    output logic [16:0] third_word,
    output logic [7:0]  first_byte,
    output logic [7:0]  second_byte,
    output logic [3:0]  low_nibble
);

    logic         accept;
    logic         pop;
    logic         has_room;
    result_pair_t results;
    result_t      head;

    assign in_ready = has_room;
    assign accept   = in_valid && has_room;
    assign pop      = out_valid && out_ready;

    // byte decode and parser state
    tmsp_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .results     (results)
    );

    // result queue
    tmsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (results),
        .pop       (pop),
        .head      (head),
        .not_empty (out_valid),
        .has_room  (has_room)
    );

    // output fields
    assign kind        = head.kind;
    assign first_word  = head.first_word;
    assign second_word = head.second_word;
    assign third_word  = head.third_word;
    assign first_byte  = head.first_byte;
    assign second_byte = head.second_byte;
    assign low_nibble  = head.low_nibble;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tracker module stream parser by sending whole module files and
// early-ending, corrupted and noisy ones. Every byte taken by the parser is
// also run through a local decoder, and each result that comes out is
// compared field by field with the oldest decoded result still pending.
// ----------------------------------------------------------------------------
module testbench;
    import tmsp_pkg::*;

    localparam int HEADER_BYTES  = int'(OFF_SIG_LAST) + 1;
    localparam int PATTERN_BYTES = 1024;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 4;

    // signature with one byte off from the usual four
    localparam logic [31:0] SIG_BROKEN = 32'h4D2E4B21;

    // how the sample and pattern bytes of a file are filled
    typedef enum logic [1:0] {
        FILL_RANDOM = 2'd0,
        FILL_ZERO   = 2'd1,
        FILL_ONES   = 2'd2,
        FILL_MIXED  = 2'd3
    } fill_t;

    // one directed file: shape, fill and, where obvious, the final kind
    typedef struct packed {
        logic [8:0]  top_entry;
        logic [31:0] signature;
        logic [15:0] cut_len;
        logic [3:0]  trailing;
        fill_t       fill;
        logic        typed;
        logic [2:0]  final_kind;
    } file_case_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        end_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [16:0] first_word;
    logic [16:0] second_word;
    logic [16:0] third_word;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [3:0]  low_nibble;

    // decoder state
    phase_t      parse_phase;
    logic [10:0] hdr_pos;
    logic [18:0] pat_count;
    logic [7:0]  pat_total;
    logic [7:0]  top_pattern;
    logic [15:0] smp_length;
    logic [15:0] smp_loop_start;
    logic [15:0] smp_loop_length;
    logic [3:0]  finetune;
    logic [7:0]  volume;
    logic [7:0]  song_len;
    logic [7:0]  song_restart;
    logic [31:0] sig_window;
    logic [23:0] note_bytes;

    result_t     pending_results[$];
    logic [7:0]  file_bytes[$];
    file_case_t  directed_cases[13];
    logic [2:0]  last_kind_seen;
    int          mismatch_count;
    int          send_idle_pct;
    int          stall_pct;
    logic        hold_arm;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;

    tracker_module_stream_parser_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .end_of_file (end_of_file),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .first_word  (first_word),
        .second_word (second_word),
        .third_word  (third_word),
        .first_byte  (first_byte),
        .second_byte (second_byte),
        .low_nibble  (low_nibble)
    );

    // clock
    always #5 clk = ~clk;

    function automatic logic is_known_signature(input logic [31:0] word);
        return word == SIG_MK || word == SIG_MK2 || word == SIG_4CHN || word == SIG_FLT4;
    endfunction

    function automatic void clear_parser();
        parse_phase     = PH_HEADER;
        hdr_pos         = '0;
        pat_count       = '0;
        pat_total       = '0;
        top_pattern     = '0;
        smp_length      = '0;
        smp_loop_start  = '0;
        smp_loop_length = '0;
        finetune        = '0;
        volume          = '0;
        song_len        = '0;
        song_restart    = '0;
        sig_window      = '0;
        note_bytes      = '0;
    endfunction

    function automatic void expect_result(input logic [2:0] k, input logic [16:0] fw,
                                          input logic [16:0] sw, input logic [16:0] tw,
                                          input logic [7:0] fb, input logic [7:0] sb,
                                          input logic [3:0] ln);
        result_t r;
        r.kind        = k;
        r.first_word  = fw;
        r.second_word = sw;
        r.third_word  = tw;
        r.first_byte  = fb;
        r.second_byte = sb;
        r.low_nibble  = ln;
        pending_results.push_back(r);
    endfunction

    // decode one file byte into the results it should produce
    function automatic void decode_byte(input logic [7:0] b, input logic eof);
        int slot;
        if (parse_phase == PH_HEADER) begin
            sig_window = {sig_window[23:0], b};
            if (hdr_pos >= OFF_SAMPLES_START && hdr_pos < OFF_SONG_LEN) begin
                // position inside the 30-byte sample record
                slot = int'(hdr_pos - OFF_SAMPLES_START) % 30;
                case (slot)
                    22: smp_length = {b, 8'h00};
                    23: smp_length[7:0] = b;
                    24: finetune = b[3:0];
                    25: volume = b;
                    26: smp_loop_start = {b, 8'h00};
                    27: smp_loop_start[7:0] = b;
                    28: smp_loop_length = {b, 8'h00};
                    29:
                    begin
                        smp_loop_length[7:0] = b;
                        expect_result(KIND_SAMPLE, {smp_length, 1'b0},
                                      {smp_loop_start, 1'b0}, {smp_loop_length, 1'b0},
                                      volume, 8'd0, finetune);
                    end
                    default: ;
                endcase
            end else if (hdr_pos == OFF_SONG_LEN) begin
                song_len = b;
            end else if (hdr_pos == OFF_RESTART) begin
                song_restart = b;
            end else if (hdr_pos >= OFF_TABLE_START && hdr_pos < OFF_TABLE_END) begin
                if (b > top_pattern)
                    top_pattern = b;
            end
            // signature complete: song header or an error
            if (hdr_pos >= OFF_SIG_LAST) begin
                if (!is_known_signature(sig_window)) begin
                    expect_result(KIND_BAD_SIG, '0, '0, '0, '0, '0, '0);
                    parse_phase = PH_FINISHED;
                end else begin
                    pat_total = top_pattern + 8'd1;
                    if (pat_total == 8'd0) begin
                        expect_result(KIND_NO_PATTERNS, '0, '0, '0, '0, '0, '0);
                        parse_phase = PH_FINISHED;
                    end else begin
                        expect_result(KIND_SONG, {9'd0, pat_total}, '0, '0,
                                      song_len, song_restart, '0);
                        parse_phase = PH_PATTERN;
                        pat_count   = '0;
                    end
                end
            end else begin
                hdr_pos = hdr_pos + 11'd1;
            end
            if (eof && parse_phase != PH_FINISHED)
                expect_result(KIND_SHORT_FILE, '0, '0, '0, '0, '0, '0);
        end else if (parse_phase == PH_PATTERN) begin
            // four bytes per note, the fourth one completes it
            if (pat_count[1:0] != 2'd3)
                note_bytes = {note_bytes[15:0], b};
            else
                expect_result(KIND_NOTE, {5'd0, note_bytes[19:16], note_bytes[15:8]}, '0, '0,
                              {note_bytes[23:20], note_bytes[7:4]}, b, note_bytes[3:0]);
            pat_count = pat_count + 19'd1;
            if (pat_count >= {1'b0, pat_total, 10'd0}) begin
                expect_result(KIND_DONE, '0, '0, '0, '0, '0, '0);
                parse_phase = PH_FINISHED;
            end else if (eof) begin
                expect_result(KIND_SHORT_FILE, '0, '0, '0, '0, '0, '0);
            end
        end
        if (eof)
            clear_parser();
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatch_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    function automatic void check_result();
        result_t want;
        last_kind_seen = kind;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            $error("kind: expected nothing, got %0d", kind);
        end else begin
            want = pending_results.pop_front();
            compare_field("kind", int'(want.kind), int'(kind));
            compare_field("first_word", int'(want.first_word), int'(first_word));
            compare_field("second_word", int'(want.second_word), int'(second_word));
            compare_field("third_word", int'(want.third_word), int'(third_word));
            compare_field("first_byte", int'(want.first_byte), int'(first_byte));
            compare_field("second_byte", int'(want.second_byte), int'(second_byte));
            compare_field("low_nibble", int'(want.low_nibble), int'(low_nibble));
        end
    endfunction

    // results out first, then the byte taken at the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                check_result();
            if (in_valid && in_ready)
                decode_byte(data_byte, end_of_file);
        end
    end

    // receiver: random stalls, or a long hold-off when armed
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_arm != hold_seen) begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [7:0] fill_byte(input fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] good_signature();
        case ($urandom_range(0, 3))
            0:       return SIG_MK;
            1:       return SIG_MK2;
            2:       return SIG_4CHN;
            default: return SIG_FLT4;
        endcase
    endfunction

    // lay out one module file, cut short at cut_len when that is nonzero
    function automatic void build_module_file(input int top_entry, input logic [31:0] signature,
                                              input int cut_len, input int trailing,
                                              input fill_t fill);
        int nominal;
        int len;
        int table_hit;
        int i;
        fill_t mode;
        logic [7:0] b;
        nominal = HEADER_BYTES + trailing;
        if (is_known_signature(signature) && top_entry < 255)
            nominal += (top_entry + 1) * PATTERN_BYTES;
        len = (cut_len > 0 && cut_len < nominal) ? cut_len : nominal;
        table_hit = int'(OFF_TABLE_START) + $urandom_range(0, 127);
        mode = fill;
        file_bytes.delete();
        for (i = 0; i < len; i++) begin
            // mixed fill picks a new style for every sample record
            if (fill == FILL_MIXED && i >= int'(OFF_SAMPLES_START) && i < int'(OFF_SONG_LEN)
                && (i - int'(OFF_SAMPLES_START)) % 30 == 0)
                mode = fill_t'($urandom_range(0, 2));
            if (i < int'(OFF_SAMPLES_START) || i == int'(OFF_SONG_LEN) || i == int'(OFF_RESTART))
                b = 8'($urandom_range(0, 255));
            else if (i < int'(OFF_SONG_LEN))
                b = fill_byte(mode);
            else if (i < int'(OFF_TABLE_END))
                b = (i == table_hit) ? top_entry[7:0] : 8'($urandom_range(0, top_entry));
            else if (i < HEADER_BYTES)
                b = signature[8 * (HEADER_BYTES - 1 - i) +: 8];
            else
                b = fill_byte(fill);
            file_bytes.push_back(b);
        end
    endfunction

    // one request, with an optional random gap in front
    task automatic offer_byte(input logic [7:0] value, input logic eof_flag);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        data_byte   <= value;
        end_of_file <= eof_flag;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic stream_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            offer_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_results_drained();
        int spins;
        in_valid <= 1'b0;
        @(posedge clk);
        spins = 0;
        while (pending_results.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        if (pending_results.size() != 0) begin
            mismatch_count++;
            $error("kind: expected %0d, got nothing", pending_results[0].kind);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_module_file();
        int pick;
        int sel;
        int top_entry;
        int cut_len;
        int trailing;
        int count;
        int k;
        logic [31:0] signature;
        logic [31:0] mask;
        pick      = $urandom_range(0, 99);
        signature = good_signature();
        top_entry = 0;
        cut_len   = 0;
        trailing  = 0;
        if (pick < 50) begin
            // well-formed file, mostly one pattern, sometimes cut in the patterns
            sel = $urandom_range(0, 19);
            top_entry = (sel < 15) ? 0 : (sel < 19) ? 1 : $urandom_range(2, 254);
            if (top_entry > 1)
                cut_len = HEADER_BYTES + $urandom_range(1, 1200);
            else if ($urandom_range(0, 1))
                cut_len = $urandom_range(HEADER_BYTES + 1,
                                         HEADER_BYTES + (top_entry + 1) * PATTERN_BYTES - 1);
            if ($urandom_range(0, 99) < 40)
                trailing = $urandom_range(1, 4);
        end else if (pick < 60) begin
            // signature with one byte damaged, or random
            if ($urandom_range(0, 1)) begin
                mask = $urandom_range(1, 255);
                signature = signature ^ (mask << (8 * $urandom_range(0, 3)));
            end else begin
                signature = $urandom;
            end
            trailing = $urandom_range(0, 6);
        end else if (pick < 68) begin
            // pattern count wraps to zero
            top_entry = 255;
            trailing  = $urandom_range(0, 4);
        end else if (pick < 90) begin
            cut_len = $urandom_range(1, HEADER_BYTES - 1);
        end
        if (pick < 90) begin
            build_module_file(top_entry, signature, cut_len, trailing, FILL_MIXED);
            stream_file();
        end else begin
            // noise with end-of-file marks at random places
            count = $urandom_range(1, 300);
            for (k = 0; k < count; k++)
                offer_byte(8'($urandom_range(0, 255)),
                           k == count - 1 || $urandom_range(0, 49) == 0);
        end
    endtask

    // run time limit
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int k;
        int p;
        int f;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'd0;
        end_of_file    = 1'b0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        hold_arm       = 1'b0;
        mismatch_count = 0;
        last_kind_seen = '0;
        clear_parser();

        // top entry, signature, cut, trailing, fill, typed, final kind
        directed_cases[0]  = '{9'd0, SIG_MK, 16'd1, 4'd0, FILL_RANDOM, 1'b1, KIND_SHORT_FILE};
        directed_cases[1]  = '{9'd0, SIG_MK, 16'd50, 4'd0, FILL_ONES, 1'b1, KIND_SHORT_FILE};
        directed_cases[2]  = '{9'd0, SIG_MK, 16'd1083, 4'd0, FILL_ZERO, 1'b1, KIND_SHORT_FILE};
        directed_cases[3]  = '{9'd0, SIG_MK, 16'd0, 4'd0, FILL_ZERO, 1'b1, KIND_DONE};
        directed_cases[4]  = '{9'd0, SIG_MK2, 16'd0, 4'd3, FILL_ONES, 1'b1, KIND_DONE};
        directed_cases[5]  = '{9'd0, SIG_4CHN, 16'd1084, 4'd0, FILL_RANDOM, 1'b1,
                               KIND_SHORT_FILE};
        directed_cases[6]  = '{9'd1, SIG_FLT4, 16'd1088, 4'd0, FILL_RANDOM, 1'b1,
                               KIND_SHORT_FILE};
        directed_cases[7]  = '{9'd1, SIG_FLT4, 16'd0, 4'd0, FILL_MIXED, 1'b0, KIND_DONE};
        directed_cases[8]  = '{9'd254, SIG_MK, 16'd1092, 4'd0, FILL_RANDOM, 1'b1,
                               KIND_SHORT_FILE};
        directed_cases[9]  = '{9'd255, SIG_MK, 16'd0, 4'd2, FILL_RANDOM, 1'b1,
                               KIND_NO_PATTERNS};
        directed_cases[10] = '{9'd255, SIG_4CHN, 16'd1084, 4'd0, FILL_RANDOM, 1'b1,
                               KIND_NO_PATTERNS};
        directed_cases[11] = '{9'd0, SIG_BROKEN, 16'd0, 4'd5, FILL_RANDOM, 1'b1, KIND_BAD_SIG};
        directed_cases[12] = '{9'd0, 32'h0, 16'd1084, 4'd0, FILL_RANDOM, 1'b1, KIND_BAD_SIG};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed files, each drained before the next
        for (k = 0; k < 13; k++) begin
            build_module_file(int'(directed_cases[k].top_entry), directed_cases[k].signature,
                              int'(directed_cases[k].cut_len), int'(directed_cases[k].trailing),
                              directed_cases[k].fill);
            stream_file();
            wait_results_drained();
            if (directed_cases[k].typed && last_kind_seen != directed_cases[k].final_kind) begin
                mismatch_count++;
                $error("kind: expected %0d, got %0d", directed_cases[k].final_kind,
                       last_kind_seen);
            end
        end

        // random files under each idling mix
        for (p = 0; p < 4; p++) begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 50;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 50;
                end
                default:
                begin
                    send_idle_pct = 8;
                    stall_pct    <= 8;
                end
            endcase
            if (p == 0) begin
                // long receiver hold-off while a full file keeps coming
                hold_arm <= ~hold_arm;
                build_module_file(0, SIG_MK, 0, 0, FILL_MIXED);
                stream_file();
            end
            for (f = 0; f < 8; f++)
                random_module_file();
            wait_results_drained();
        end

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
